// ===== rtl/srr_pkg.sv =====
// srr_pkg: shared types and constants of the selective repeat receiver
// field widths of the stream payloads, result kinds and the sequencer state encoding
// no dependencies
package srr_pkg;

  // packet and result field widths
  localparam int unsigned SeqW     = 3;
  localparam int unsigned PayloadW = 64;

  // stream data width: sequence number plus payload, padded to whole bytes
  localparam int unsigned TdataW   = 72;

  // result kinds carried on the output tuser
  localparam logic KindAck     = 1'b0;
  localparam logic KindDeliver = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_DELIVER
  } state_e;

endpackage

// ===== rtl/selective_repeat_receiver_unit.sv =====
// Selective repeat ARQ receiver.
// Input stream s_axis: one packet per transfer; tdata carries the sequence
// number and the payload word, tuser the checksum-ok flag from upstream.
// Output stream m_axis: result items; tuser is the kind (0 acknowledgement,
// 1 delivered payload), tdata carries ack number and delivered data, tlast
// marks the final result of a packet.
// A packet with a bad checksum is dropped in its accept cycle, no result.
// A good packet is stored when it falls inside the window, then acknowledged
// with its own sequence number, then every in-order slot at the window head
// is delivered and the window slides.
// Sequencing: one packet gives 1 ack plus 0..WINDOW deliveries; the sequencer
// handles one packet at a time and emits one result per cycle through the
// output register while m_axis is not stalled. Deliveries stream from the
// payload memory, whose read address follows the next head so the registered
// read of the head slot is ready when that slot is delivered.
// The first result is loaded into the output register in the ack state after
// the accept and is held there until m_axis takes it.
// Reset clears the received flags, the window head and the base number; the
// payload memory is not cleared. A stalled m_axis holds the output register
// and the ack and deliver states; s_axis is ready only between packets.
module selective_repeat_receiver_unit #(
  parameter int unsigned WINDOW    = 4,
  parameter int unsigned SEQ_SPACE = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input packets
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [srr_pkg::TdataW-1:0]  s_axis_tdata,  // seq_num[2:0], payload[66:3], zero pad
  input  logic                        s_axis_tuser,  // checksum_ok
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [srr_pkg::TdataW-1:0]  m_axis_tdata,  // ack_num[2:0], data[66:3], zero pad
  output logic                        m_axis_tuser,  // kind
  output logic                        m_axis_tlast   // last
);

  localparam int unsigned SW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int unsigned HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned PadW = srr_pkg::TdataW - srr_pkg::SeqW - srr_pkg::PayloadW;
  localparam int unsigned RedSteps = ((1 << srr_pkg::SeqW) + SEQ_SPACE - 1) / SEQ_SPACE;

  // input field split
  logic [srr_pkg::SeqW-1:0]     in_seq;
  logic [srr_pkg::PayloadW-1:0] in_payload;
  assign in_seq     = s_axis_tdata[srr_pkg::SeqW-1:0];
  assign in_payload = s_axis_tdata[srr_pkg::SeqW +: srr_pkg::PayloadW];

  // state
  srr_pkg::state_e state_q, state_d;
  logic [WINDOW-1:0]           rcv_q, rcv_d;
  logic [HW-1:0]               head_q, head_d;
  logic [SW-1:0]               base_q, base_d;
  logic [srr_pkg::SeqW-1:0]    ack_seq_q, ack_seq_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_kind_q, out_kind_d;
  logic [srr_pkg::SeqW-1:0]    out_ack_q, out_ack_d;
  logic [srr_pkg::PayloadW-1:0] out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;

  // memory port signals
  logic                        mem_we;
  logic [HW-1:0]               mem_waddr;
  logic [srr_pkg::PayloadW-1:0] mem_rdata;

  // offset of the arriving packet from the window base
  logic [srr_pkg::SeqW-1:0] seq_red;
  logic [SW-1:0]  seq_mod;
  logic [SW:0]    diff;
  logic [SW:0]    off_ext;
  logic [SW-1:0]  offset;
  logic           in_win;
  int unsigned    phys_sum;
  logic [HW-1:0]  phys;

  // sequence number folded into the sequence space by compare and subtract
  always_comb begin
    seq_red = in_seq;
    for (int unsigned k = 0; k < RedSteps; k++) begin
      if (32'(seq_red) >= SEQ_SPACE) begin
        seq_red = seq_red - srr_pkg::SeqW'(SEQ_SPACE);
      end
    end
  end

  assign seq_mod = SW'(seq_red);
  assign diff    = {1'b0, seq_mod} - {1'b0, base_q};
  assign off_ext = diff[SW] ? diff + (SW+1)'(SEQ_SPACE) : diff;
  assign offset  = off_ext[SW-1:0];
  assign in_win  = 32'(offset) < WINDOW;

  // physical slot: head plus offset, wrapped at the window size
  assign phys_sum = 32'(head_q) + 32'(offset);
  assign phys     = HW'((phys_sum >= WINDOW) ? phys_sum - WINDOW : phys_sum);

  // head and base successors
  logic [HW-1:0] head_inc;
  logic [SW-1:0] base_inc;
  assign head_inc = (32'(head_q) == WINDOW - 1) ? '0 : head_q + 1'b1;
  assign base_inc = (32'(base_q) == SEQ_SPACE - 1) ? '0 : base_q + 1'b1;

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // received flags with the head slot cleared
  logic [WINDOW-1:0] rcv_clr;
  always_comb begin
    rcv_clr         = rcv_q;
    rcv_clr[head_q] = 1'b0;
  end

  // sequencer: next state and output register load
  always_comb begin
    state_d       = state_q;
    rcv_d         = rcv_q;
    head_d        = head_q;
    base_d        = base_q;
    ack_seq_d     = ack_seq_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_kind_d    = out_kind_q;
    out_ack_d     = out_ack_q;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    mem_we        = 1'b0;
    mem_waddr     = phys;
    s_axis_tready = 1'b0;
    case (state_q)
      srr_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tuser) begin
          ack_seq_d = in_seq;
          if (in_win) begin
            mem_we      = 1'b1;
            rcv_d[phys] = 1'b1;
          end
          state_d = srr_pkg::S_ACK;
        end
      end
      srr_pkg::S_ACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = srr_pkg::KindAck;
          out_ack_d   = ack_seq_q;
          out_data_d  = '0;
          out_last_d  = !rcv_q[head_q];
          state_d     = rcv_q[head_q] ? srr_pkg::S_DELIVER : srr_pkg::S_IDLE;
        end
      end
      srr_pkg::S_DELIVER: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = srr_pkg::KindDeliver;
          out_ack_d   = '0;
          out_data_d  = mem_rdata;
          out_last_d  = !rcv_clr[head_inc];
          rcv_d       = rcv_clr;
          head_d      = head_inc;
          base_d      = base_inc;
          state_d     = rcv_clr[head_inc] ? srr_pkg::S_DELIVER : srr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srr_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srr_pkg::S_IDLE;
      rcv_q       <= '0;
      head_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rcv_q       <= rcv_d;
      head_q      <= head_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ack_seq_q  <= ack_seq_d;
    out_kind_q <= out_kind_d;
    out_ack_q  <= out_ack_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // payload store, read address tracks the next head
  srr_window_mem #(
    .Depth (WINDOW),
    .AddrW (HW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_payload),
    .raddr_i (head_d),
    .rdata_o (mem_rdata)
  );

  // output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {PadW'(0), out_data_q, out_ack_q};

`ifndef SYNTH
  // a delivery only ever reads a slot that holds a received payload
  a_deliver_received: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srr_pkg::S_DELIVER |-> rcv_q[head_q])
    else $error("delivery from an empty window slot");

  // a good packet always leads to its acknowledgement
  a_good_to_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> state_q == srr_pkg::S_ACK)
    else $error("accepted packet not acknowledged");

  // a corrupt packet leaves the sequencer idle
  a_bad_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> state_q == srr_pkg::S_IDLE)
    else $error("corrupt packet started a result sequence");

  // the head slot and the base number slide together
  a_slide_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(head_q) |-> !$stable(base_q))
    else $error("window head moved without the base number");
`endif

endmodule

// ===== rtl/srr_window_mem.sv =====
// srr_window_mem: payload store of the receive window
// one write port, one read port with registered read data
// depends on srr_pkg for the payload width
module srr_window_mem #(
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = 2
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AddrW-1:0]                  waddr_i,
  input  logic [srr_pkg::PayloadW-1:0]      wdata_i,
  input  logic [AddrW-1:0]                  raddr_i,
  output logic [srr_pkg::PayloadW-1:0]      rdata_o
);

  logic [srr_pkg::PayloadW-1:0] mem_q [Depth];
  logic [srr_pkg::PayloadW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/tb_selective_repeat_receiver_unit.sv =====
// tb_selective_repeat_receiver_unit: self-checking bench for the selective repeat receiver
// drives packets on s_axis, checks each m_axis transfer against a window predictor or typed row
// depends on srr_pkg and selective_repeat_receiver_unit
module tb_selective_repeat_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEQ_W        = srr_pkg::SeqW;
  localparam int unsigned DATA_W       = srr_pkg::PayloadW;
  localparam int unsigned TDATA_W      = srr_pkg::TdataW;
  localparam int unsigned WINDOW_SLOTS = 4;
  localparam int unsigned SEQ_MOD      = 8;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned QUIET_ITEMS  = 60;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;

  // result kinds on m_axis_tuser
  localparam logic KIND_ACK     = srr_pkg::KindAck;
  localparam logic KIND_DELIVER = srr_pkg::KindDeliver;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  ack_num;
    logic [DATA_W-1:0] data;
    logic              last;
  } srr_result_t;

  // directed row: typed rows carry their result in the row itself
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              ok;
    logic [DATA_W-1:0] payload;
    logic              typed;
    logic              own_delivery;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  // receive window copy
  logic              window_full [WINDOW_SLOTS];
  logic [DATA_W-1:0] window_word [WINDOW_SLOTS];
  logic [SEQ_W-1:0]  head_seq;

  srr_result_t predicted[$];
  srr_result_t pending_results[$];
  stim_row_t   dir_rows[$];

  bit quiet;
  int unsigned mismatches;
  int unsigned missing;
  int unsigned cycle_count;
  int unsigned packets_sent;
  int unsigned corrupt_sent;
  int unsigned outside_sent;
  int unsigned acks_seen;
  int unsigned deliveries_seen;
  int unsigned full_bursts;

  selective_repeat_receiver_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // seq_num[2:0], payload[66:3], zero pad
    .s_axis_tuser  (s_axis_tuser),   // checksum_ok
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // ack_num[2:0], data[66:3], zero pad
    .m_axis_tuser  (m_axis_tuser),   // kind
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("selective_repeat_receiver_unit regression: fail");
      $finish;
    end
  end

  // append one expected result
  function automatic void queue_result(input logic kind, input logic [SEQ_W-1:0] ack,
                                       input logic [DATA_W-1:0] data, input logic last);
    srr_result_t r;
    r.kind    = kind;
    r.ack_num = ack;
    r.data    = data;
    r.last    = last;
    predicted.insert(predicted.size(), r);
  endfunction

  // append one directed row to the table
  function automatic void add_row(input logic [SEQ_W-1:0] seq, input logic ok,
                                  input logic [DATA_W-1:0] payload, input logic typed,
                                  input logic own_delivery);
    stim_row_t row;
    row.seq          = seq;
    row.ok           = ok;
    row.payload      = payload;
    row.typed        = typed;
    row.own_delivery = own_delivery;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // window predictor: ack first, then in-order deliveries from the head
  task automatic predict_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                                input logic [DATA_W-1:0] payload);
    int unsigned offset;
    if (!ok) begin
      corrupt_sent++;
      return;
    end
    offset = (int'(seq) + SEQ_MOD - int'(head_seq)) % SEQ_MOD;
    if (offset < WINDOW_SLOTS) begin
      window_full[offset] = 1'b1;
      window_word[offset] = payload;
    end else begin
      outside_sent++;
    end
    queue_result(KIND_ACK, seq, {DATA_W{1'b0}}, 1'b0);
    for (int d = 0; d < WINDOW_SLOTS && window_full[0]; d++) begin
      queue_result(KIND_DELIVER, {SEQ_W{1'b0}}, window_word[0], 1'b0);
      for (int i = 0; i + 1 < WINDOW_SLOTS; i++) begin
        window_full[i] = window_full[i+1];
        window_word[i] = window_word[i+1];
      end
      window_full[WINDOW_SLOTS-1] = 1'b0;
      window_word[WINDOW_SLOTS-1] = '0;
      head_seq = head_seq + 1'b1;
    end
    if (predicted.size() == WINDOW_SLOTS + 1) full_bursts++;
    predicted[predicted.size()-1].last = 1'b1;
  endtask

  // one packet transfer, with an optional idle burst in front
  task automatic send_packet(input stim_row_t row);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-DATA_W-SEQ_W){1'b0}}, row.payload, row.seq};
    s_axis_tuser  <= row.ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    packets_sent++;
    predicted.delete();
    predict_packet(row.seq, row.ok, row.payload);
    if (row.typed) begin
      // result read straight off the row
      predicted.delete();
      if (row.ok) begin
        queue_result(KIND_ACK, row.seq, {DATA_W{1'b0}}, !row.own_delivery);
        if (row.own_delivery)
          queue_result(KIND_DELIVER, {SEQ_W{1'b0}}, row.payload, 1'b1);
      end
    end
    foreach (predicted[k]) pending_results.insert(pending_results.size(), predicted[k]);
    predicted.delete();
  endtask

  function automatic void report_mismatch(string what, srr_result_t want,
                                          srr_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%s: expected kind %0d ack %0d data %h last %0d, %s %0d ack %0d data %h last %0d",
               what, want.kind, want.ack_num, want.data, want.last,
               "got kind", got.kind, got.ack_num, got.data, got.last);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    srr_result_t got;
    srr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[SEQ_W-1:0],
              m_axis_tdata[SEQ_W+DATA_W-1:SEQ_W], m_axis_tlast};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.kind !== want.kind || got.ack_num !== want.ack_num ||
            got.data !== want.data || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
        if (want.kind == KIND_ACK) acks_seen++;
        else deliveries_seen++;
      end
    end
  end

  // result side backpressure in random bursts
  initial begin
    int unsigned span;
    logic        level;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        span  = $urandom_range(1, 8);
        level = ($urandom_range(0, 99) >= 35);
        repeat (span) begin
          @(negedge clk_i);
          m_axis_tready <= level;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t   row;
    int unsigned pick;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    quiet         = 1'b0;
    head_seq      = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      window_full[i] = 1'b0;
      window_word[i] = '0;
    end

    // directed rows: seq, ok, payload, typed, own delivery
    add_row(3'd0, 1'b1, 64'h0, 1'b1, 1'b1);
    add_row(3'd1, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);
    // corrupt packet is dropped
    add_row(3'd2, 1'b0, 64'hdead_beef_dead_beef, 1'b1, 1'b0);
    add_row(3'd2, 1'b1, 64'ha5a5_5a5a_a5a5_5a5a, 1'b1, 1'b1);
    // holes at the head: stored, acked only
    add_row(3'd5, 1'b1, 64'h0000_0000_0000_0005, 1'b1, 1'b0);
    add_row(3'd6, 1'b1, 64'h0000_0000_0000_0006, 1'b1, 1'b0);
    // just past the window: acked, not stored
    add_row(3'd7, 1'b1, 64'h7777_7777_7777_7777, 1'b1, 1'b0);
    // duplicate inside the window overwrites
    add_row(3'd5, 1'b1, 64'h5555_aaaa_5555_aaaa, 1'b1, 1'b0);
    add_row(3'd4, 1'b1, 64'h0000_0000_0000_0004, 1'b1, 1'b0);
    // fills the head: ack plus four deliveries
    add_row(3'd3, 1'b1, 64'h0000_0000_0000_0003, 1'b0, 1'b0);
    add_row(3'd2, 1'b1, 64'h2222_0000_2222_0000, 1'b1, 1'b0);
    // old retransmission below the base
    add_row(3'd6, 1'b1, 64'h6666_6666_6666_6666, 1'b1, 1'b0);
    add_row(3'd7, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
    add_row(3'd1, 1'b1, 64'h1111_0000_1111_0000, 1'b1, 1'b0);
    add_row(3'd0, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f, 1'b1, 1'b0);
    // window wraps through the sequence space
    add_row(3'd7, 1'b1, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
    add_row(3'd3, 1'b1, 64'h0, 1'b1, 1'b1);
    add_row(3'd4, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_packet(dir_rows[i]);

    // hold off until the directed results are all out
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // random part: mostly in-window traffic, some outside, some corrupt
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      pick        = $urandom_range(0, 99);
      row.payload = {$urandom, $urandom};
      row.typed   = 1'b0;
      row.own_delivery = 1'b0;
      row.ok      = 1'b1;
      if (pick < 10) begin
        row.ok  = 1'b0;
        row.seq = SEQ_W'($urandom_range(0, SEQ_MOD - 1));
      end else if (pick < 22) begin
        row.seq = SEQ_W'(32'(head_seq) + $urandom_range(WINDOW_SLOTS, SEQ_MOD - 1));
      end else begin
        row.seq = SEQ_W'(32'(head_seq) + $urandom_range(0, WINDOW_SLOTS - 1));
      end
      send_packet(row);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    missing = pending_results.size();
    if (missing != 0) begin
      $display("%0d expected results never arrived", missing);
    end

    $display("covered %0d packets (%0d corrupt, %0d outside the window) in %0d cycles",
             packets_sent, corrupt_sent, outside_sent, cycle_count);
    $display("matched %0d acks, %0d deliveries, %0d full window releases, %0d mismatches",
             acks_seen, deliveries_seen, full_bursts, mismatches);
    if (mismatches == 0 && missing == 0) begin
      $display("selective_repeat_receiver_unit regression: pass");
    end else begin
      $display("selective_repeat_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
